### rtl/esc_telemetry_frame_decoder_unit_defines.svh
// Assertion macros shared by the telemetry frame decoder RTL.
`ifndef ESC_TELEMETRY_FRAME_DECODER_UNIT_DEFINES_SVH
`define ESC_TELEMETRY_FRAME_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and masked during reset.
`define ETFD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and masked during reset.
`define ETFD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/etfd_pkg.sv
// Types and constants of the telemetry frame decoder.
`timescale 1ns / 1ps
package etfd_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [4:0] t_idx;

    // Window and frame geometry.
    localparam t_idx WIN_LEN    = 5'd22;
    localparam t_idx WIN_LAST   = 5'd21;
    localparam t_idx FRAME_LEN  = 5'd20;
    localparam t_idx FRAME_LAST = 5'd19;
    localparam t_idx SUM_LEN    = 5'd18;

    // Byte offsets of the fields inside a frame.
    localparam t_idx OFS_VOLT  = 5'd0;
    localparam t_idx OFS_TEMP  = 5'd2;
    localparam t_idx OFS_CURR  = 5'd4;
    localparam t_idx OFS_RPM   = 5'd8;
    localparam t_idx OFS_IDUTY = 5'd12;
    localparam t_idx OFS_MDUTY = 5'd14;
    localparam t_idx OFS_STAT  = 5'd16;
    localparam t_idx OFS_CSUM  = 5'd18;

    localparam t_byte BYTE_MARK = 8'hFF;
    localparam logic [8:0] FL_MOD = 9'd255;

    // Reciprocal constants: x*2/25 = (x*RCP_CURR) >> 21, x/10 = (x*RCP_DUTY) >> 19,
    // both exact over the full 16-bit input range.
    localparam logic [17:0] RCP_CURR = 18'd167773;
    localparam logic [17:0] RCP_DUTY = 18'd52429;

    localparam int CURR_W = 13;
    localparam int DUTY_W = 13;
    localparam int RPM_W  = 31;

    typedef struct packed {
        logic clear;
        logic en;
    } t_fl_ctrl;

endpackage

### rtl/etfd_if.sv
// Handshake channels for received bytes and decoded frames.
`timescale 1ns / 1ps
interface etfd_in_if import etfd_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface etfd_out_if import etfd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [15:0]       voltage_raw;
    logic [15:0]       temperature_raw;
    logic [CURR_W-1:0] supply_current;
    logic [RPM_W-1:0]  motor_rpm;
    logic [DUTY_W-1:0] throttle_duty;
    logic [DUTY_W-1:0] drive_duty;
    t_byte             esc_status;
    logic              checksum_ok;

    modport source (output valid, output voltage_raw, output temperature_raw,
                    output supply_current, output motor_rpm, output throttle_duty,
                    output drive_duty, output esc_status, output checksum_ok,
                    input ready);
    modport sink   (input valid, input voltage_raw, input temperature_raw,
                    input supply_current, input motor_rpm, input throttle_duty,
                    input drive_duty, input esc_status, input checksum_ok,
                    output ready);
endinterface

### rtl/etfd_fletcher.sv
// Fletcher-16 accumulator taking one frame byte per cycle while enabled.
`timescale 1ns / 1ps
module etfd_fletcher import etfd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_fl_ctrl    i_ctrl,
    input  t_byte       i_byte,
    output logic [15:0] o_sum
);

    logic [7:0] r_s0;
    logic [7:0] r_s1;
    logic [8:0] w_a0;
    logic [8:0] w_a1;
    logic [7:0] n_s0;
    logic [7:0] n_s1;

    // Both sums stay below 255, so one conditional subtract reduces each add.
    always_comb begin
        w_a0 = {1'b0, r_s0} + {1'b0, i_byte};
        n_s0 = (w_a0 >= FL_MOD) ? 8'(w_a0 - FL_MOD) : w_a0[7:0];
        w_a1 = {1'b0, r_s1} + {1'b0, n_s0};
        n_s1 = (w_a1 >= FL_MOD) ? 8'(w_a1 - FL_MOD) : w_a1[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_s0 <= 8'd0;
            r_s1 <= 8'd0;
        end else if (i_ctrl.en) begin
            r_s0 <= n_s0;
            r_s1 <= n_s1;
        end
    end

    assign o_sum = {r_s1, r_s0};

endmodule

### rtl/esc_telemetry_frame_decoder_unit.sv
// Top level of the telemetry frame decoder: byte window memory, frame sweep and field decode.
`timescale 1ns / 1ps
`include "esc_telemetry_frame_decoder_unit_defines.svh"
// Each received word is written into a 22-entry circular byte memory, and i_rx.ready stays
// high while no frame is being decoded. When a word completes a frame (two consecutive 0xFF
// words once at least 22 words have arrived), the block drops ready and sweeps the 20 frame
// bytes out of the memory through its single read port, one byte per cycle, feeding a
// Fletcher-16 accumulator and the field registers. Three divisions in turn on one shared
// multiplier produce the current and duty quotients, and the S_LOAD state then loads the
// output register and returns ready, waiting there while the previous result has not yet
// been taken. The output register lets further words be taken while a result waits. No
// clearing pass is needed after reset.
module esc_telemetry_frame_decoder_unit import etfd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    etfd_in_if.sink           i_rx,
    etfd_out_if.source        o_res
);

    typedef enum logic [1:0] {S_IDLE, S_READ, S_MUL, S_LOAD} t_state;

    t_state r_state;

    // Byte window memory and its pointers.
    t_byte r_mem [WIN_LEN];
    t_byte r_rd_data;
    t_idx  r_wptr;
    t_idx  r_cnt;
    logic  r_last_ff;
    t_idx  r_rd_ptr;
    t_idx  r_rd_cnt;
    logic  r_rd_vld;
    t_idx  r_rd_idx;

    // Frame fields gathered during the sweep.
    logic [15:0] r_volt;
    logic [15:0] r_temp;
    logic [15:0] r_curr;
    logic [31:0] r_rpm;
    logic [15:0] r_iduty;
    logic [15:0] r_mduty;
    t_byte       r_stat;
    logic [15:0] r_csum;

    logic [1:0]        r_mul_idx;
    logic [CURR_W-1:0] r_q_curr;
    logic [DUTY_W-1:0] r_q_iduty;
    logic [DUTY_W-1:0] r_q_mduty;

    // Output register.
    logic              r_o_valid;
    logic [15:0]       r_o_volt;
    logic [15:0]       r_o_temp;
    logic [CURR_W-1:0] r_o_curr;
    logic [RPM_W-1:0]  r_o_rpm;
    logic [DUTY_W-1:0] r_o_iduty;
    logic [DUTY_W-1:0] r_o_mduty;
    t_byte             r_o_stat;
    logic              r_o_csum_ok;

    logic        w_in_acc;
    logic        w_frame_hit;
    logic        w_rd_en;
    logic        w_out_free;
    t_idx        n_wptr;
    t_idx        n_cnt;
    t_idx        n_rd_ptr;
    logic [15:0] w_mul_op;
    logic [17:0] w_mul_k;
    logic [33:0] w_prod;
    t_fl_ctrl    w_fl_ctrl;
    logic [15:0] w_fl_sum;

    assign i_rx.ready = (r_state == S_IDLE);
    assign w_in_acc   = i_rx.valid && i_rx.ready;
    assign w_out_free = !r_o_valid || o_res.ready;

    always_comb begin
        n_wptr   = (r_wptr == WIN_LAST) ? '0 : r_wptr + 5'd1;
        n_cnt    = (r_cnt == WIN_LEN) ? r_cnt : r_cnt + 5'd1;
        n_rd_ptr = (r_rd_ptr == WIN_LAST) ? '0 : r_rd_ptr + 5'd1;
    end

    assign w_frame_hit = w_in_acc && r_last_ff && (i_rx.rx_byte == BYTE_MARK)
                         && (n_cnt == WIN_LEN);
    assign w_rd_en     = (r_state == S_READ) && (r_rd_cnt < FRAME_LEN);

    // Writes happen only while idle and reads only during the sweep, so they never collide.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mem[r_wptr] <= i_rx.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    assign w_fl_ctrl.clear = w_frame_hit;
    assign w_fl_ctrl.en    = r_rd_vld && (r_rd_idx < SUM_LEN);

    etfd_fletcher u_fletcher (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_fl_ctrl),
        .i_byte  (r_rd_data),
        .o_sum   (w_fl_sum)
    );

    // One shared multiplier for the three reciprocal divisions.
    always_comb begin
        case (r_mul_idx)
            2'd0: begin
                w_mul_op = r_curr;
                w_mul_k  = RCP_CURR;
            end
            2'd1: begin
                w_mul_op = r_iduty;
                w_mul_k  = RCP_DUTY;
            end
            default: begin
                w_mul_op = r_mduty;
                w_mul_k  = RCP_DUTY;
            end
        endcase
        w_prod = {18'd0, w_mul_op} * {16'd0, w_mul_k};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wptr    <= '0;
            r_cnt     <= '0;
            r_last_ff <= 1'b0;
            r_rd_ptr  <= '0;
            r_rd_cnt  <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_idx  <= '0;
            r_mul_idx <= '0;
            r_o_valid <= 1'b0;
        end else begin
            // A result taken in the same cycle as a new load is replaced, not cleared.
            if (r_o_valid && o_res.ready && !((r_state == S_LOAD) && w_out_free)) begin
                r_o_valid <= 1'b0;
            end
            r_rd_vld <= w_rd_en;
            r_rd_idx <= r_rd_cnt;

            if (r_rd_vld) begin
                unique case (r_rd_idx)
                    OFS_VOLT:          r_volt[7:0]   <= r_rd_data;
                    OFS_VOLT + 5'd1:   r_volt[15:8]  <= r_rd_data;
                    OFS_TEMP:          r_temp[7:0]   <= r_rd_data;
                    OFS_TEMP + 5'd1:   r_temp[15:8]  <= r_rd_data;
                    OFS_CURR:          r_curr[7:0]   <= r_rd_data;
                    OFS_CURR + 5'd1:   r_curr[15:8]  <= r_rd_data;
                    OFS_RPM:           r_rpm[7:0]    <= r_rd_data;
                    OFS_RPM + 5'd1:    r_rpm[15:8]   <= r_rd_data;
                    OFS_RPM + 5'd2:    r_rpm[23:16]  <= r_rd_data;
                    OFS_RPM + 5'd3:    r_rpm[31:24]  <= r_rd_data;
                    OFS_IDUTY:         r_iduty[7:0]  <= r_rd_data;
                    OFS_IDUTY + 5'd1:  r_iduty[15:8] <= r_rd_data;
                    OFS_MDUTY:         r_mduty[7:0]  <= r_rd_data;
                    OFS_MDUTY + 5'd1:  r_mduty[15:8] <= r_rd_data;
                    OFS_STAT:          r_stat        <= r_rd_data;
                    OFS_CSUM:          r_csum[7:0]   <= r_rd_data;
                    OFS_CSUM + 5'd1:   r_csum[15:8]  <= r_rd_data;
                    default:           ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_wptr    <= n_wptr;
                        r_cnt     <= n_cnt;
                        r_last_ff <= (i_rx.rx_byte == BYTE_MARK);
                    end
                    if (w_frame_hit) begin
                        // The oldest word of the window sits just past the one written now.
                        r_rd_ptr <= n_wptr;
                        r_rd_cnt <= '0;
                        r_state  <= S_READ;
                    end
                end
                S_READ: begin
                    if (w_rd_en) begin
                        r_rd_ptr <= n_rd_ptr;
                        r_rd_cnt <= r_rd_cnt + 5'd1;
                    end
                    if (r_rd_vld && (r_rd_idx == FRAME_LAST)) begin
                        r_mul_idx <= '0;
                        r_state   <= S_MUL;
                    end
                end
                S_MUL: begin
                    case (r_mul_idx)
                        2'd0:    r_q_curr  <= w_prod[33:21];
                        2'd1:    r_q_iduty <= w_prod[31:19];
                        default: r_q_mduty <= w_prod[31:19];
                    endcase
                    r_mul_idx <= r_mul_idx + 2'd1;
                    if (r_mul_idx == 2'd2) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (w_out_free) begin
                        r_o_valid   <= 1'b1;
                        r_o_volt    <= r_volt;
                        r_o_temp    <= r_temp;
                        r_o_curr    <= r_q_curr;
                        r_o_rpm     <= r_rpm[31:1];
                        r_o_iduty   <= r_q_iduty;
                        r_o_mduty   <= r_q_mduty;
                        r_o_stat    <= r_stat;
                        r_o_csum_ok <= (w_fl_sum == r_csum);
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid           = r_o_valid;
    assign o_res.voltage_raw     = r_o_volt;
    assign o_res.temperature_raw = r_o_temp;
    assign o_res.supply_current  = r_o_curr;
    assign o_res.motor_rpm       = r_o_rpm;
    assign o_res.throttle_duty   = r_o_iduty;
    assign o_res.drive_duty      = r_o_mduty;
    assign o_res.esc_status      = r_o_stat;
    assign o_res.checksum_ok     = r_o_csum_ok;

    `ETFD_ASSERT_NXT(a_frame_starts_sweep, w_frame_hit, (r_state == S_READ) && !i_rx.ready,
                     "frame detection did not start the byte sweep")
    `ETFD_ASSERT_NXT(a_sweep_ends, r_rd_vld && (r_rd_idx == FRAME_LAST), r_state == S_MUL,
                     "last frame byte did not start the divisions")
    `ETFD_ASSERT_IMP(a_ptr_range, 1'b1,
                     (r_wptr < WIN_LEN) && (r_rd_ptr < WIN_LEN) && (r_cnt <= WIN_LEN),
                     "window pointer or count out of range")
    `ETFD_ASSERT_NXT(a_load_fills_output, (r_state == S_LOAD) && w_out_free,
                     o_res.valid && (r_state == S_IDLE),
                     "result was not loaded into a free output register")

endmodule
